// ----- rtl/lbs_pkg.sv -----
`timescale 1ns / 1ps
package lbs_pkg;
    localparam int MAX_BONES   = 64;
    localparam int INFLUENCES  = 4;
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = 10;
    localparam int BONE_W      = 6;
    localparam int INF_W       = 2;
    localparam int Q_DEPTH     = 2;
    localparam logic [3:0] MARGIN_WORD = 4'd12;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_SKIN = 1'b1;

    // one skin job handed from the front end to the back end
    typedef struct packed {
        logic signed [31:0]   px;
        logic signed [31:0]   py;
        logic signed [31:0]   pz;
        logic [3:0]           used;
        logic [3:0][15:0]     w;
        logic [3:0][BONE_W-1:0] bone;
    } job_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction
endpackage

// ----- rtl/linear_blend_skinning.sv -----
`timescale 1ns / 1ps
// Four-influence linear blend skinning. A load beat writes one word of the
// 1024-word bone table and is taken only when no skin job is queued. A skin
// beat is queued (two entries) and then worked one influence at a time: each
// used influence reads its 13 table words through the single table port. The
// next job starts once the result of the one before it has been taken. A
// vertex with no used influence gives zero. The job stays queued until its
// last weight multiply, so a load waits behind every queued skin. The table
// holds garbage until written.
module linear_blend_skinning (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic [9:0]           table_address,
    input  logic signed [31:0]   table_value,
    input  logic signed [31:0]   pos_x,
    input  logic signed [31:0]   pos_y,
    input  logic signed [31:0]   pos_z,
    input  logic [31:0]          weights_low,
    input  logic [31:0]          weights_high,
    input  logic [23:0]          bone_indices,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   out_x,
    output logic signed [31:0]   out_y,
    output logic signed [31:0]   out_z,
    output logic signed [31:0]   out_margin
);
    import lbs_pkg::*;

    logic        wr_en;
    logic [9:0]  wr_addr;
    logic [31:0] wr_data;
    logic        job_valid;
    logic        job_done;
    job_t        job;

    lbs_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .action, .table_address, .table_value,
        .pos_x, .pos_y, .pos_z, .weights_low, .weights_high, .bone_indices,
        .wr_en, .wr_addr, .wr_data, .job_valid, .job_done, .job
    );

    lbs_back u_back (
        .clk, .rst_n, .wr_en, .wr_addr, .wr_data, .job_valid, .job_done, .job,
        .out_valid, .out_stall, .out_x, .out_y, .out_z, .out_margin
    );
endmodule

// ----- rtl/lbs_front.sv -----
`timescale 1ns / 1ps
// Classifies beats: loads go to the table write port, skins are queued as jobs.
module lbs_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      action,
    input  logic [9:0]                table_address,
    input  logic signed [31:0]        table_value,
    input  logic signed [31:0]        pos_x,
    input  logic signed [31:0]        pos_y,
    input  logic signed [31:0]        pos_z,
    input  logic [31:0]               weights_low,
    input  logic [31:0]               weights_high,
    input  logic [23:0]               bone_indices,
    output logic                      wr_en,
    output logic [9:0]                wr_addr,
    output logic [31:0]               wr_data,
    output logic                      job_valid,
    input  logic                      job_done,
    output lbs_pkg::job_t             job
);
    import lbs_pkg::*;

    job_t       q_reg [Q_DEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    job_t       nj;
    logic       push;
    logic       pop;

    always_comb
    begin
        nj.px = pos_x;
        nj.py = pos_y;
        nj.pz = pos_z;
        nj.w[0] = weights_low[15:0];
        nj.w[1] = weights_low[31:16];
        nj.w[2] = weights_high[15:0];
        nj.w[3] = weights_high[31:16];
        for (int i = 0; i < 4; i++)
        begin
            nj.bone[i] = bone_indices[i*BONE_W +: BONE_W];
            nj.used[i] = (i < INFLUENCES) && (nj.w[i] != 16'd0)
                         && ({1'b0, nj.bone[i]} < 7'(MAX_BONES));
        end
    end

    // a load is not taken while a skin job could still read the table;
    // the head job stays queued until the back end is done with it
    assign in_stall  = (action == ACT_SKIN) ? (cnt_reg == 2'(Q_DEPTH))
                                            : (cnt_reg != 2'd0);
    assign push      = in_valid && !in_stall && action == ACT_SKIN;
    assign pop       = job_valid && job_done;
    assign job_valid = cnt_reg != 2'd0;
    assign job       = q_reg[rp_reg];
    assign wr_en     = in_valid && !in_stall && action == ACT_LOAD;
    assign wr_addr   = table_address;
    assign wr_data   = table_value;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= nj;
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'(Q_DEPTH))
        else $error("job queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> cnt_reg == 2'd0)
        else $error("table written under a pending job");
    assert property (@(posedge clk) disable iff (!rst_n) !(push && wr_en))
        else $error("load and skin in one beat");
endmodule

// ----- rtl/lbs_back.sv -----
`timescale 1ns / 1ps
// Per job: one influence per step, 13 table reads per influence through one port.
module lbs_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [9:0]           wr_addr,
    input  logic [31:0]          wr_data,
    input  logic                 job_valid,
    output logic                 job_done,
    input  lbs_pkg::job_t        job,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   out_x,
    output logic signed [31:0]   out_y,
    output logic signed [31:0]   out_z,
    output logic signed [31:0]   out_margin
);
    import lbs_pkg::*;

    logic [31:0] mem [TABLE_DEPTH];
    logic signed [31:0] rd_reg;

    // sequencer: reads words 0 to 12 in order, data valid next cycle
    logic        busy_reg, busy_next;
    logic [1:0]  inf_reg, inf_next;
    logic [3:0]  word_reg, word_next;
    logic        dv_reg;           // rd_reg holds word dw_reg
    logic [3:0]  dw_reg;
    logic [1:0]  di_reg;
    logic        last_reg;         // final word of the job is in rd_reg
    logic        fin_reg;          // accumulators complete
    logic        ov_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg, om_reg;

    logic signed [63:0] prod_reg;
    logic        pv_reg;
    logic [3:0]  pw_reg;
    logic [1:0]  pi_reg;
    logic        pl_reg;
    logic signed [63:0] hi_reg;
    logic [17:0] lo_reg;
    logic signed [31:0] lane_reg;
    logic        lv_reg;
    logic [1:0]  lr_reg;
    logic [1:0]  li_reg;
    logic        ll_reg;
    logic signed [31:0] wl_reg;
    logic signed [49:0] wp_reg;
    logic        wv_reg;
    logic [1:0]  wr_lane;
    logic        wl_last;
    logic signed [53:0] acc_reg [4];
    logic        al_reg;
    logic [9:0]  rd_addr;
    logic        step;
    logic [1:0]  first_used;
    logic        any_used;
    logic        have_next;
    logic [1:0]  next_inf;
    logic signed [31:0] pcoord;
    logic        job_take;
    logic        pend_any;

    always_comb
    begin
        any_used = job.used != 4'd0;
        first_used = 2'd0;
        for (int i = 3; i >= 0; i--)
            if (job.used[i])
                first_used = 2'(i);
        have_next = 1'b0;
        next_inf  = inf_reg;
        for (int i = 3; i >= 0; i--)
            if (job.used[i] && 2'(i) > inf_reg)
            begin
                have_next = 1'b1;
                next_inf  = 2'(i);
            end
    end

    // a new job waits until the pipeline has drained and no stall holds the result
    assign pend_any = dv_reg | pv_reg | lv_reg | wv_reg | al_reg | fin_reg | (ov_reg & out_stall);
    assign job_take = job_valid && !busy_reg && !pend_any;
    // head job is released after its last weight multiply
    assign job_done = (lv_reg && ll_reg) || (job_take && !any_used);

    always_comb
    begin
        busy_next = busy_reg;
        inf_next  = inf_reg;
        word_next = word_reg;
        step      = 1'b0;
        if (job_take && any_used)
        begin
            busy_next = 1'b1;
            inf_next  = first_used;
            word_next = 4'd0;
        end
        else if (busy_reg)
        begin
            step = 1'b1;
            if (word_reg == MARGIN_WORD)
            begin
                word_next = 4'd0;
                if (have_next)
                    inf_next = next_inf;
                else
                    busy_next = 1'b0;
            end
            else
                word_next = word_reg + 4'd1;
        end
    end

    assign rd_addr = {job.bone[inf_reg], word_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    always_comb
    begin
        case (dw_reg[1:0])
            2'd0:    pcoord = job.px;
            2'd1:    pcoord = job.py;
            default: pcoord = job.pz;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            inf_reg  <= 2'd0;
            word_reg <= 4'd0;
            dv_reg   <= 1'b0;
            pv_reg   <= 1'b0;
            lv_reg   <= 1'b0;
            wv_reg   <= 1'b0;
            al_reg   <= 1'b0;
            fin_reg  <= 1'b0;
            ov_reg   <= 1'b0;
            last_reg <= 1'b0;
            pl_reg   <= 1'b0;
            ll_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            inf_reg  <= inf_next;
            word_reg <= word_next;
            dv_reg   <= step;
            last_reg <= step && !busy_next;
            // stage 1: multiply or pass through
            pv_reg   <= dv_reg;
            pl_reg   <= last_reg;
            // stage 2: row sum finished at column 3 / margin word
            lv_reg   <= pv_reg && (pw_reg[1:0] == 2'd3 || pw_reg == MARGIN_WORD);
            ll_reg   <= pl_reg;
            wv_reg   <= lv_reg;
            al_reg   <= wv_reg && wl_last;
            fin_reg  <= al_reg || (job_take && !any_used);
            if (fin_reg)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        dw_reg <= word_reg;
        di_reg <= inf_reg;
        // stage 1
        pw_reg <= dw_reg;
        pi_reg <= di_reg;
        if (dw_reg[1:0] == 2'd3 || dw_reg == MARGIN_WORD)
            prod_reg <= 64'(rd_reg);
        else
            prod_reg <= rd_reg * pcoord;
        // stage 2: Q32.32 row accumulate
        if (pv_reg)
        begin
            if (pw_reg == MARGIN_WORD)
            begin
                lane_reg <= prod_reg[31:0];
                lr_reg   <= 2'd3;
            end
            else if (pw_reg[1:0] == 2'd0)
            begin
                hi_reg <= prod_reg >>> 16;
                lo_reg <= 18'(prod_reg[15:0]);
            end
            else if (pw_reg[1:0] == 2'd3)
            begin
                lane_reg <= sat32(hi_reg + 64'(($unsigned(lo_reg) + 18'h8000) >> 16)
                                  + prod_reg);
                lr_reg   <= pw_reg[3:2];
            end
            else
            begin
                hi_reg <= hi_reg + (prod_reg >>> 16);
                lo_reg <= lo_reg + 18'(prod_reg[15:0]);
            end
        end
        li_reg <= pi_reg;
        // stage 3: weight multiply
        wp_reg  <= lane_reg * $signed({1'b0, job.w[li_reg]});
        wr_lane <= lr_reg;
        wl_last <= ll_reg && lr_reg == 2'd3;
        // stage 4: accumulate lanes
        if (job_take)
            for (int j = 0; j < 4; j++)
                acc_reg[j] <= '0;
        else if (wv_reg)
            acc_reg[wr_lane] <= acc_reg[wr_lane] + 54'(wp_reg);
        if (fin_reg)
        begin
            ox_reg <= sat32(64'((acc_reg[0] + 54'sh4000) >>> 15));
            oy_reg <= sat32(64'((acc_reg[1] + 54'sh4000) >>> 15));
            oz_reg <= sat32(64'((acc_reg[2] + 54'sh4000) >>> 15));
            om_reg <= sat32(64'((acc_reg[3] + 54'sh4000) >>> 15));
        end
    end

    assign out_valid  = ov_reg;
    assign out_x      = ox_reg;
    assign out_y      = oy_reg;
    assign out_z      = oz_reg;
    assign out_margin = om_reg;

    assert property (@(posedge clk) disable iff (!rst_n) job_take |-> !busy_reg)
        else $error("job taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> job_valid)
        else $error("job left queue while in work");
    assert property (@(posedge clk) disable iff (!rst_n) fin_reg |=> ov_reg)
        else $error("result lost");
endmodule

// ----- test/tb_linear_blend_skinning.sv -----
`timescale 1ns / 1ps
module tb_linear_blend_skinning;
    import lbs_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic              action;
        logic [9:0]        addr;
        logic signed [31:0] value;
        logic signed [31:0] px, py, pz;
        logic [31:0]       wl, wh;
        logic [23:0]       bones;
    } vertex_beat_t;

    typedef struct packed {
        logic signed [31:0] x, y, z, m;
    } skinned_t;

    class skin_scoreboard;
        logic signed [31:0] bone_words [TABLE_DEPTH];
        bit                 written [TABLE_DEPTH];
        skinned_t           expected_q [$];
        int                 mismatches;

        function logic signed [31:0] clip(input logic signed [95:0] v);
            if (v > 96'sd2147483647)
                return 32'sh7fffffff;
            if (v < -96'sd2147483648)
                return 32'sh80000000;
            return v[31:0];
        endfunction

        function bit bone_ready(input int bone);
            for (int k = 0; k <= int'(MARGIN_WORD); k++)
                if (!written[bone * 16 + k])
                    return 0;
            return 1;
        endfunction

        function void note_beat(input vertex_beat_t b);
            logic signed [95:0] acc [4];
            logic signed [95:0] pos [3];
            logic signed [95:0] row, wt, lane;
            logic [15:0] w;
            int base;
            skinned_t r;
            if (b.action == ACT_LOAD)
            begin
                bone_words[b.addr] = b.value;
                written[b.addr] = 1;
                return;
            end
            pos[0] = b.px;
            pos[1] = b.py;
            pos[2] = b.pz;
            for (int j = 0; j < 4; j++)
                acc[j] = 0;
            for (int i = 0; i < INFLUENCES; i++)
            begin
                w = (i < 2) ? b.wl[16 * (i % 2) +: 16] : b.wh[16 * (i % 2) +: 16];
                if (w == 0)
                    continue;
                base = int'(b.bones[6 * i +: 6]) * 16;
                wt = $signed({1'b0, w});
                for (int j = 0; j < 3; j++)
                begin
                    row = 0;
                    for (int k = 0; k < 3; k++)
                    begin
                        lane = bone_words[base + 4 * j + k];
                        row += lane * pos[k];
                    end
                    lane = ((row + 96'sd32768) >>> 16) + bone_words[base + 4 * j + 3];
                    lane = clip(lane);
                    acc[j] += lane * wt;
                end
                lane = bone_words[base + int'(MARGIN_WORD)];
                acc[3] += lane * wt;
            end
            r.x = clip((acc[0] + 96'sd16384) >>> 15);
            r.y = clip((acc[1] + 96'sd16384) >>> 15);
            r.z = clip((acc[2] + 96'sd16384) >>> 15);
            r.m = clip((acc[3] + 96'sd16384) >>> 15);
            expected_q = {expected_q, r};
        endfunction

        function void check_vertex(input skinned_t got);
            skinned_t exp_r;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat x=%h y=%h z=%h m=%h",
                             got.x, got.y, got.z, got.m);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got != exp_r)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp x=%h y=%h z=%h m=%h got x=%h y=%h z=%h m=%h",
                             exp_r.x, exp_r.y, exp_r.z, exp_r.m,
                             got.x, got.y, got.z, got.m);
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic action;
    logic [9:0] table_address;
    logic signed [31:0] table_value, pos_x, pos_y, pos_z;
    logic [31:0] weights_low, weights_high;
    logic [23:0] bone_indices;
    logic signed [31:0] out_x, out_y, out_z, out_margin;

    skin_scoreboard sb;
    int  idle_cycles;
    int  hold_ask, hold_seen, hold_left, stall_left;
    bit  calm;

    linear_blend_skinning dut (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2, 3: return $urandom();
            4, 5: return 32'sh10000 + $signed($urandom_range(0, 8191)) - 4096;
            default: return $signed($urandom_range(0, 262143)) - 131072;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_pos();
        if ($urandom_range(0, 5) == 0)
            return $urandom();
        return $signed($urandom_range(0, 2097151)) - 1048576;
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 7))
            0, 1: return 16'h0000;
            2: return 16'h8000;
            3: return 16'hffff;
            default: return 16'($urandom_range(1, 16'h8000));
        endcase
    endfunction

    task automatic send(input vertex_beat_t b);
        int gap;
        in_valid      <= 1'b1;
        action        <= b.action;
        table_address <= b.addr;
        table_value   <= b.value;
        pos_x         <= b.px;
        pos_y         <= b.py;
        pos_z         <= b.pz;
        weights_low   <= b.wl;
        weights_high  <= b.wh;
        bone_indices  <= b.bones;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_beat(b);
        if (calm || $urandom_range(0, 9) < 6)
            gap = 0;
        else if ($urandom_range(0, 19) == 0)
            gap = $urandom_range(20, 60);
        else
            gap = $urandom_range(1, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load_word(input int addr, input logic signed [31:0] v);
        vertex_beat_t b;
        b = '{action: ACT_LOAD, addr: addr[9:0], value: v, px: $urandom(), py: $urandom(),
              pz: $urandom(), wl: $urandom(), wh: $urandom(), bones: 24'($urandom())};
        send(b);
    endtask

    task automatic skin(input logic signed [31:0] x, y, z,
                        input logic [31:0] wl, wh, input logic [23:0] bones);
        vertex_beat_t b;
        b = '{action: ACT_SKIN, addr: 10'($urandom()), value: $urandom(), px: x, py: y,
              pz: z, wl: wl, wh: wh, bones: bones};
        send(b);
    endtask

    // zero-weight influences may point anywhere, live ones only at loaded bones
    task automatic random_skin();
        logic [15:0] w [4];
        logic [23:0] bones;
        int bone;
        for (int i = 0; i < 4; i++)
        begin
            w[i] = rand_weight();
            bone = $urandom_range(0, MAX_BONES - 1);
            if (w[i] != 0)
                while (!sb.bone_ready(bone))
                    bone = $urandom_range(0, MAX_BONES - 1);
            bones[6 * i +: 6] = bone[5:0];
        end
        skin(rand_pos(), rand_pos(), rand_pos(), {w[1], w[0]}, {w[3], w[2]}, bones);
    endtask

    initial
    begin
        sb = new();
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        action        <= ACT_LOAD;
        table_address <= '0;
        table_value   <= '0;
        pos_x         <= '0;
        pos_y         <= '0;
        pos_z         <= '0;
        weights_low   <= '0;
        weights_high  <= '0;
        bone_indices  <= '0;
        hold_ask      = 0;
        calm          = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bone 0 identity, bone 63 at the extremes, a few random bones
        for (int k = 0; k <= int'(MARGIN_WORD); k++)
            load_word(k, (k == 0 || k == 5 || k == 10) ? 32'sh10000 : 32'sh0);
        for (int k = 0; k <= int'(MARGIN_WORD); k++)
            load_word(63 * 16 + k, (k % 2) ? 32'sh80000000 : 32'sh7fffffff);
        for (int bn = 1; bn < 6; bn++)
            for (int k = 0; k <= int'(MARGIN_WORD); k++)
                load_word(bn * 16 + k, rand_q());
        load_word(1023, 32'sh7fffffff);
        load_word(63 * 16 + 13, 32'sh80000000);

        // directed vertices
        skin(32'sh12345, -32'sh777, 32'sh1, 32'h0, 32'h0, 24'hffffff);
        skin(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'h00008000, 32'h0, 24'h0);
        skin(32'sh10000, 32'sh20000, -32'sh30000, 32'h80008000, 32'h80008000, 24'h0);
        skin(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'hffffffff, 32'hffffffff,
             24'hffffff);
        skin(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'hffffffff, 32'hffffffff,
             24'hffffff);
        skin(32'sh1, -32'sh1, 32'sh8000, 32'h00010000, 32'h00000001, {6'd0, 6'd63, 6'd2, 6'd1});
        skin(32'sh4000, 32'sh8000, -32'sh8000, 32'h40004000, 32'h40004000,
             {6'd5, 6'd4, 6'd3, 6'd2});
        skin(32'sh0, 32'sh0, 32'sh0, 32'h00000000, 32'hffff0000, {6'd63, 6'd9, 6'd9, 6'd9});

        // full stall on the result side while vertices keep coming
        hold_ask++;
        calm = 1;
        for (int n = 0; n < 20; n++)
            random_skin();
        calm = 0;

        for (int n = 0; n < 380; n++)
        begin
            if (n % 60 == 0)
                calm = $urandom_range(0, 2) == 0;
            if (n == 250)
                hold_ask++;
            if ($urandom_range(0, 9) < 3)
                load_word($urandom_range(0, TABLE_DEPTH - 1), rand_q());
            else
                random_skin();
        end
        in_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            hold_seen  <= 0;
            hold_left  <= 0;
            stall_left <= 0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_ask != hold_seen)
        begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (calm || $urandom_range(0, 2) != 0)
        begin
            out_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 20);
        end
        else
        begin
            out_stall  <= 1'b1;
            stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 3);
        end
    end

    // result beats and the hang watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_vertex('{x: out_x, y: out_y, z: out_z, m: out_margin});
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
        else
            idle_cycles <= 0;
    end
endmodule

// ----- filelist.f -----
rtl/lbs_pkg.sv
rtl/lbs_front.sv
rtl/lbs_back.sv
rtl/linear_blend_skinning.sv
test/tb_linear_blend_skinning.sv
